[src/amef_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// amef_pkg
// Shared types and constants for the anaglyph merge with edge fade block.
// ----------------------------------------------------------------------------
package amef_pkg;

    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 2048;

    localparam int CFG_W  = 12;
    localparam int IDX_W  = 2;
    localparam int PIX_W  = 8;
    localparam int COL_W  = 11;
    localparam int ROW_W  = 11;
    localparam int PROD_W = PIX_W + COL_W;
    localparam int BIT_W  = $clog2(PIX_W);

    localparam logic [CFG_W-1:0] MAX_W_CFG   = CFG_W'(MAX_WIDTH);
    localparam logic [CFG_W-1:0] MAX_H_CFG   = CFG_W'(MAX_HEIGHT);
    localparam logic [CFG_W-1:0] RST_WIDTH   = CFG_W'(640);
    localparam logic [CFG_W-1:0] RST_HEIGHT  = CFG_W'(480);
    localparam logic [CFG_W-1:0] RST_FADE    = '0;

    localparam logic [IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [IDX_W-1:0] REG_FADE_WIDTH   = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_DONE
    } amef_state_t;

    typedef struct packed {
        logic load;
        logic mul;
        logic mul_second;
        logic step;
        logic last_step;
        logic out_load;
        logic [BIT_W-1:0] bit_idx;
    } amef_cmd_t;

    typedef struct packed {
        logic [1:0] num_passes;
    } amef_status_t;

endpackage

[src/amef_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// amef_ctrl
// Sequencer: accepts an item, runs the fade passes, hands the item to the
// output register.
// ----------------------------------------------------------------------------
module amef_ctrl
    import amef_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_valid,
    output logic         s_ready,
    output logic         m_valid,
    input  logic         m_ready,
    input  amef_status_t status,
    output amef_cmd_t    cmd
);

    amef_state_t      state_reg, state_next;
    logic [BIT_W-1:0] bit_reg, bit_next;
    logic             second_reg, second_next;
    logic             m_valid_reg, m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            bit_reg     <= '0;
            second_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            bit_reg     <= bit_next;
            second_reg  <= second_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Next state.
    always_comb begin
        state_next  = state_reg;
        bit_next    = bit_reg;
        second_next = second_reg;
        case (state_reg)
            ST_IDLE: begin
                second_next = 1'b0;
                if (s_valid) begin
                    if (status.num_passes == 2'd0) begin
                        state_next = ST_DONE;
                    end else begin
                        state_next = ST_MUL;
                    end
                end
            end
            ST_MUL: begin
                bit_next   = BIT_W'(PIX_W - 1);
                state_next = ST_DIV;
            end
            ST_DIV: begin
                bit_next = bit_reg - 1'b1;
                if (bit_reg == '0) begin
                    if (second_reg || status.num_passes == 2'd1) begin
                        state_next = ST_DONE;
                    end else begin
                        second_next = 1'b1;
                        state_next  = ST_MUL;
                    end
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs.
    always_comb begin
        s_ready        = (state_reg == ST_IDLE);
        cmd.load       = s_valid && (state_reg == ST_IDLE);
        cmd.mul        = (state_reg == ST_MUL);
        cmd.mul_second = second_reg;
        cmd.step       = (state_reg == ST_DIV);
        cmd.last_step  = (bit_reg == '0);
        cmd.bit_idx    = bit_reg;
        cmd.out_load   = (state_reg == ST_DONE) && (!m_valid_reg || m_ready);
        m_valid_next   = m_valid_reg;
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

[src/amef_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// amef_datapath
// Configuration registers, raster position, fade factor selection and three
// shift-subtract divider lanes with the output register.
// ----------------------------------------------------------------------------
module amef_datapath
    import amef_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_valid,
    input  logic [IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0] cfg_data,
    input  logic [PIX_W-1:0] s_right_blue,
    input  logic [PIX_W-1:0] s_right_green,
    input  logic [PIX_W-1:0] s_left_red,
    input  amef_cmd_t        cmd,
    output amef_status_t     status,
    output logic [PIX_W-1:0] m_out_blue,
    output logic [PIX_W-1:0] m_out_green,
    output logic [PIX_W-1:0] m_out_red,
    output logic             m_end_of_row,
    output logic             m_end_of_frame
);

    logic [CFG_W-1:0] width_reg, height_reg, fade_reg;
    logic [COL_W-1:0] col_reg;
    logic [ROW_W-1:0] row_reg;

    logic [CFG_W-1:0] f_reg;
    logic [COL_W-1:0] k1_reg, k2_reg;
    logic [1:0]       npass_reg;
    logic             eor_reg, eof_reg;

    logic [PIX_W-1:0]  v_reg   [3];
    logic [PROD_W-1:0] rem_reg [3];
    logic [PIX_W-1:0]  q_reg   [3];

    logic [PIX_W-1:0] out_blue_reg, out_green_reg, out_red_reg;
    logic             out_eor_reg, out_eof_reg;

    // Geometry for the pixel at the current position.
    logic [CFG_W-1:0] w_c, h_c, f_c, wm1, hm1;
    logic [COL_W-1:0] c_eff, dr, k_lo, k_hi;
    logic             last_col, last_row, use_l, use_r;
    logic [1:0]       npass_c;

    always_comb begin
        if (width_reg == '0) begin
            w_c = CFG_W'(1);
        end else if (width_reg > MAX_W_CFG) begin
            w_c = MAX_W_CFG;
        end else begin
            w_c = width_reg;
        end
        if (height_reg == '0) begin
            h_c = CFG_W'(1);
        end else if (height_reg > MAX_H_CFG) begin
            h_c = MAX_H_CFG;
        end else begin
            h_c = height_reg;
        end
        f_c = (fade_reg > w_c) ? w_c : fade_reg;
        wm1 = w_c - 1'b1;
        hm1 = h_c - 1'b1;
        c_eff = ({1'b0, col_reg} > wm1) ? wm1[COL_W-1:0] : col_reg;
        dr = wm1[COL_W-1:0] - c_eff;
        last_col = ({1'b0, c_eff} == wm1);
        last_row = ({1'b0, row_reg} >= hm1);
        use_l = (f_c != '0) && ({1'b0, c_eff} < f_c);
        use_r = (f_c != '0) && ({1'b0, dr} < f_c);
        if (use_l && use_r) begin
            k_lo    = (c_eff < dr) ? c_eff : dr;
            k_hi    = (c_eff < dr) ? dr : c_eff;
            npass_c = 2'd2;
        end else if (use_l) begin
            k_lo    = c_eff;
            k_hi    = c_eff;
            npass_c = 2'd1;
        end else begin
            k_lo    = dr;
            k_hi    = dr;
            npass_c = use_r ? 2'd1 : 2'd0;
        end
    end

    // The status reflects the pass count for an item about to be taken
    // and, afterwards, the count held for the item in progress.
    assign status.num_passes = cmd.load ? npass_c : npass_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= RST_WIDTH;
            height_reg <= RST_HEIGHT;
            fade_reg   <= RST_FADE;
            col_reg    <= '0;
            row_reg    <= '0;
            npass_reg  <= '0;
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    REG_IMAGE_WIDTH:  width_reg  <= cfg_data;
                    REG_IMAGE_HEIGHT: height_reg <= cfg_data;
                    REG_FADE_WIDTH:   fade_reg   <= cfg_data;
                    default: ;
                endcase
            end
            if (cmd.load) begin
                npass_reg <= npass_c;
                if (last_col) begin
                    col_reg <= '0;
                    row_reg <= last_row ? '0 : row_reg + 1'b1;
                end else begin
                    col_reg <= c_eff + 1'b1;
                end
            end
        end
    end

    // Item registers and the divider lanes.
    logic [PROD_W:0]   div_sh;
    logic [COL_W-1:0]  k_sel;
    logic [PROD_W:0]   rem_x   [3];
    logic              ge      [3];
    logic [PROD_W-1:0] rem_sub [3];
    logic [PROD_W-1:0] prod    [3];

    always_comb begin
        div_sh = (PROD_W + 1)'(f_reg) << cmd.bit_idx;
        k_sel  = cmd.mul_second ? k2_reg : k1_reg;
        for (int i = 0; i < 3; i++) begin
            rem_x[i]   = {1'b0, rem_reg[i]};
            ge[i]      = (rem_x[i] >= div_sh);
            rem_sub[i] = PROD_W'(rem_x[i] - div_sh);
            prod[i]    = PROD_W'({{COL_W{1'b0}}, v_reg[i]} * {{PIX_W{1'b0}}, k_sel});
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            v_reg[0] <= s_right_blue;
            v_reg[1] <= s_right_green;
            v_reg[2] <= s_left_red;
            f_reg    <= f_c;
            k1_reg   <= k_lo;
            k2_reg   <= k_hi;
            eor_reg  <= last_col;
            eof_reg  <= last_col && last_row;
        end
        for (int i = 0; i < 3; i++) begin
            if (cmd.mul) begin
                rem_reg[i] <= prod[i];
                q_reg[i]   <= '0;
            end else if (cmd.step) begin
                if (ge[i]) begin
                    rem_reg[i] <= rem_sub[i];
                end
                q_reg[i] <= {q_reg[i][PIX_W-2:0], ge[i]};
                if (cmd.last_step) begin
                    v_reg[i] <= {q_reg[i][PIX_W-2:0], ge[i]};
                end
            end
        end
        if (cmd.out_load) begin
            out_blue_reg  <= v_reg[0];
            out_green_reg <= v_reg[1];
            out_red_reg   <= v_reg[2];
            out_eor_reg   <= eor_reg;
            out_eof_reg   <= eof_reg;
        end
    end

    assign m_out_blue     = out_blue_reg;
    assign m_out_green    = out_green_reg;
    assign m_out_red      = out_red_reg;
    assign m_end_of_row   = out_eor_reg;
    assign m_end_of_frame = out_eof_reg;

endmodule

[src/anaglyph_merge_edge_fade_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// anaglyph_merge_edge_fade_core
// Red-cyan anaglyph merge of paired camera pixels with side-edge fading.
// ----------------------------------------------------------------------------
// The input channel (s_valid/s_ready) takes one item per pixel pair in raster
// order: blue and green of the right camera and red of the left camera. The
// result channel (m_valid/m_ready) gives one anaglyph item per input item,
// with end-of-row and end-of-frame flags from the block's own column and row
// counters. The configuration channel (cfg_valid/cfg_ready, cfg_index,
// cfg_data) writes image width (0), image height (1) and fade width (2); it
// is always ready and a write takes effect at once without moving the
// position. Other indices are ignored.
// Each faded channel is multiplied by its distance from the edge and divided
// by the fade width in a shift-subtract divider, one quotient bit per cycle,
// with the three colour channels in parallel lanes. An item needs 0, 1 or 2
// passes (one per edge that applies), each a multiply step followed by one
// divide step per quotient bit. A new item is taken only once the block is
// back in idle after handing the previous result to the output register.
// The output register lets a new item be accepted while the previous result
// still waits; when the receiver stalls and both are full, the block holds
// in its final state until the result is taken.
// Reset restores width 640, height 480, no fading and position zero.
// ----------------------------------------------------------------------------
module anaglyph_merge_edge_fade_core
    import amef_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0] cfg_data,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [PIX_W-1:0] s_right_blue,
    input  logic [PIX_W-1:0] s_right_green,
    input  logic [PIX_W-1:0] s_left_red,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [PIX_W-1:0] m_out_blue,
    output logic [PIX_W-1:0] m_out_green,
    output logic [PIX_W-1:0] m_out_red,
    output logic             m_end_of_row,
    output logic             m_end_of_frame
);

    amef_cmd_t    cmd;
    amef_status_t status;

    // Register writes never stall.
    assign cfg_ready = 1'b1;

    // Sequencer for acceptance, fade passes and output handover.
    amef_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // Position tracking, factor selection, divider lanes and output register.
    amef_datapath u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_right_blue   (s_right_blue),
        .s_right_green  (s_right_green),
        .s_left_red     (s_left_red),
        .cmd            (cmd),
        .status         (status),
        .m_out_blue     (m_out_blue),
        .m_out_green    (m_out_green),
        .m_out_red      (m_out_red),
        .m_end_of_row   (m_end_of_row),
        .m_end_of_frame (m_end_of_frame)
    );

endmodule
